// ===== src/rpc_pkg.sv =====
package rpc_pkg;

	localparam int DIM   = 6;
	localparam int COL_W = 2 * DIM;
	localparam int ROW_W = 3;

	// column word: row 0 entry in the top two bits, {first, second} per entry,
	// so the column word itself is the full sort key
	typedef logic [COL_W-1:0] col_t;
	typedef col_t [DIM-1:0]   pat_t;
	typedef logic [DIM-1:0]   fkey_t;
	typedef logic [3:0]       class_t;

	typedef enum logic [2:0] {
		CMD_ORDER       = 3'd0,
		CMD_MOD_ORDER   = 3'd1,
		CMD_TRANSPOSE   = 3'd2,
		CMD_FIRST_ORDER = 3'd3,
		CMD_TOGGLE_ROW  = 3'd4
	} cmd_e;

	localparam class_t CLASS_1 = 4'd1;
	localparam class_t CLASS_2 = 4'd2;
	localparam class_t CLASS_3 = 4'd3;
	localparam class_t CLASS_4 = 4'd4;
	localparam class_t CLASS_5 = 4'd5;
	localparam class_t CLASS_6 = 4'd6;
	localparam class_t CLASS_7 = 4'd7;
	localparam class_t CLASS_8 = 4'd8;

	typedef struct packed {
		logic valid;
		logic sort_b;    // lane B orders on first bits
		logic sel_full;  // result taken from the fully ordered lane
	} ctl_t;

	function automatic logic first_bit(col_t col, int r);
		return col[COL_W-1-2*r];
	endfunction

	function automatic logic second_bit(col_t col, int r);
		return col[COL_W-2-2*r];
	endfunction

	function automatic fkey_t first_key(col_t col);
		fkey_t k;
		for (int r = 0; r < DIM; r++) begin
			k[DIM-1-r] = col[COL_W-1-2*r];
		end
		return k;
	endfunction

endpackage

// ===== src/rpc_prep.sv =====
module rpc_prep import rpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [2:0]        command,
	input  logic [DIM*DIM-1:0] first_bits,
	input  logic [DIM*DIM-1:0] second_bits,
	input  logic [ROW_W-1:0]  row_select,
	output ctl_t              ctl_o,
	output pat_t              pat_o
);

	ctl_t ctl_d, ctl_q;
	pat_t pat_d, pat_q;

	always_comb begin
		logic f_b;
		logic s_b;
		logic tog;
		pat_d = '0;
		for (int c = 0; c < DIM; c++) begin
			for (int r = 0; r < DIM; r++) begin
				if (command == CMD_TRANSPOSE) begin
					f_b = first_bits[DIM*c+r];
					s_b = second_bits[DIM*c+r];
				end else begin
					f_b = first_bits[DIM*r+c];
					s_b = second_bits[DIM*r+c];
				end
				tog = (command == CMD_MOD_ORDER) ||
				      ((command == CMD_TOGGLE_ROW) && (row_select == ROW_W'(r)));
				pat_d[c][COL_W-1-2*r] = f_b;
				pat_d[c][COL_W-2-2*r] = s_b ^ (f_b & tog);
			end
		end
		ctl_d.valid    = in_valid;
		ctl_d.sort_b   = (command == CMD_FIRST_ORDER);
		ctl_d.sel_full = (command == CMD_ORDER) || (command == CMD_MOD_ORDER) ||
		                 (command == CMD_TRANSPOSE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pat_q <= pat_d;
		end
	end

	assign ctl_o = ctl_q;
	assign pat_o = pat_q;

endmodule

// ===== src/rpc_sort_cell.sv =====
module rpc_sort_cell import rpc_pkg::*; #(
	parameter bit ODD = 1'b0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  ctl_t ctl_i,
	input  pat_t a_i,
	input  pat_t b_i,
	output ctl_t ctl_o,
	output pat_t a_o,
	output pat_t b_o
);

	pat_t a_d, b_d;
	ctl_t ctl_q;
	pat_t a_q, b_q;

	// one odd-even transposition phase; swap only on strict order, keeps ties stable
	always_comb begin
		a_d = a_i;
		b_d = b_i;
		for (int i = int'(ODD); i < DIM-1; i += 2) begin
			if (a_i[i+1] > a_i[i]) begin
				a_d[i]   = a_i[i+1];
				a_d[i+1] = a_i[i];
			end
			if (ctl_i.sort_b && (first_key(b_i[i+1]) > first_key(b_i[i]))) begin
				b_d[i]   = b_i[i+1];
				b_d[i+1] = b_i[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_q <= a_d;
			b_q <= b_d;
		end
	end

	assign ctl_o = ctl_q;
	assign a_o   = a_q;
	assign b_o   = b_q;

endmodule

// ===== src/rpc_classify.sv =====
module rpc_classify import rpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_t               ctl_i,
	input  pat_t               a_i,
	input  pat_t               b_i,
	input  logic               out_ready,
	output logic               adv,
	output logic               out_valid,
	output logic [DIM*DIM-1:0] first_bits_out,
	output logic [DIM*DIM-1:0] second_bits_out,
	output logic [3:0]         case_class
);

	logic               valid_q;
	logic [DIM*DIM-1:0] f_d, s_d, f_q, s_q;
	class_t             cls_d, cls_q;
	pat_t               sel;
	logic [4:0]         col0_top, col2_top;
	logic               a_sorted, b_sorted;

	assign adv = !valid_q || out_ready;

	always_comb begin
		sel = ctl_i.sel_full ? a_i : b_i;
		for (int c = 0; c < DIM; c++) begin
			for (int r = 0; r < DIM; r++) begin
				f_d[DIM*r+c] = first_bit(sel[c], r);
				s_d[DIM*r+c] = second_bit(sel[c], r);
			end
		end
	end

	// lane A is always the fully ordered form
	always_comb begin
		for (int r = 0; r < 5; r++) begin
			col0_top[r] = first_bit(a_i[0], r);
			col2_top[r] = first_bit(a_i[2], r);
		end
		if (!first_bit(a_i[2], 0)) begin
			if (first_bit(a_i[2], 2)) begin
				cls_d = first_bit(a_i[4], 4) ? CLASS_7 : CLASS_5;
			end else begin
				cls_d = ($countones(col0_top) > 2) ? CLASS_2 : CLASS_1;
			end
		end else if (first_bit(a_i[4], 2)) begin
			cls_d = first_bit(a_i[0], 0) ? CLASS_8 : CLASS_6;
		end else begin
			cls_d = ($countones(col2_top) > 2) ? CLASS_3 : CLASS_4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= ctl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_q   <= f_d;
			s_q   <= s_d;
			cls_q <= cls_d;
		end
	end

	assign out_valid       = valid_q;
	assign first_bits_out  = f_q;
	assign second_bits_out = s_q;
	assign case_class      = cls_q;

	always_comb begin
		a_sorted = 1'b1;
		b_sorted = 1'b1;
		for (int i = 0; i < DIM-1; i++) begin
			if (a_i[i] < a_i[i+1]) begin
				a_sorted = 1'b0;
			end
			if (first_key(b_i[i]) < first_key(b_i[i+1])) begin
				b_sorted = 1'b0;
			end
		end
	end

	a_lane_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_i.valid |-> a_sorted)
		else $error("full-key lane not in descending order after last cell");

	b_lane_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_i.valid && ctl_i.sort_b) |-> b_sorted)
		else $error("first-bit lane not in descending order after last cell");

	class_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (cls_q >= CLASS_1 && cls_q <= CLASS_8))
		else $error("class out of range");

	word_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_i.valid && adv) |=> valid_q)
		else $error("word dropped at output register");

endmodule

// ===== src/residue_pattern_canonicalizer_unit.sv =====
// Path: the input register takes the word at the accept edge, then it passes six
// compare-exchange cells and the output register before out_valid is raised.
// Throughput: one word per cycle; the whole chain advances whenever the
// output register is empty or being taken.
// Reset: arst_n clears the valid flags of every stage; payload is not reset.
module residue_pattern_canonicalizer_unit import rpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         command,
	input  logic [DIM*DIM-1:0] first_bits,
	input  logic [DIM*DIM-1:0] second_bits,
	input  logic [ROW_W-1:0]   row_select,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DIM*DIM-1:0] first_bits_out,
	output logic [DIM*DIM-1:0] second_bits_out,
	output logic [3:0]         case_class
);

	logic adv;
	ctl_t ctl_w [DIM+1];
	pat_t a_w   [DIM+1];
	pat_t b_w   [DIM+1];
	pat_t prep_pat;

	assign in_ready = adv;

	rpc_prep u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.in_valid    (in_valid),
		.command     (command),
		.first_bits  (first_bits),
		.second_bits (second_bits),
		.row_select  (row_select),
		.ctl_o       (ctl_w[0]),
		.pat_o       (prep_pat)
	);

	assign a_w[0] = prep_pat;
	assign b_w[0] = prep_pat;

	for (genvar k = 0; k < DIM; k++) begin : g_cell
		rpc_sort_cell #(
			.ODD (1'(k % 2))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.ctl_i  (ctl_w[k]),
			.a_i    (a_w[k]),
			.b_i    (b_w[k]),
			.ctl_o  (ctl_w[k+1]),
			.a_o    (a_w[k+1]),
			.b_o    (b_w[k+1])
		);
	end

	rpc_classify u_classify (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl_i           (ctl_w[DIM]),
		.a_i             (a_w[DIM]),
		.b_i             (b_w[DIM]),
		.out_ready       (out_ready),
		.adv             (adv),
		.out_valid       (out_valid),
		.first_bits_out  (first_bits_out),
		.second_bits_out (second_bits_out),
		.case_class      (case_class)
	);

endmodule

// ===== sim/tb_residue_pattern_canonicalizer_unit.sv =====
module tb_residue_pattern_canonicalizer_unit import rpc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB          = DIM * DIM;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_PRINTS  = 40;

	localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

	// grid[col][row] = {first, second}
	typedef logic [DIM-1:0][DIM-1:0][1:0] grid_t;

	typedef struct packed {
		logic [NB-1:0] first;
		logic [NB-1:0] second;
		class_t        cls;
	} result_t;

	typedef struct packed {
		logic [2:0]    cmd;
		logic [NB-1:0] first;
		logic [NB-1:0] second;
		logic [2:0]    rsel;
		logic          typed;
		result_t       want;
	} stim_row_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [2:0]        command     = '0;
	logic [NB-1:0]     first_bits  = '0;
	logic [NB-1:0]     second_bits = '0;
	logic [ROW_W-1:0]  row_select  = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [NB-1:0]     first_bits_out;
	logic [NB-1:0]     second_bits_out;
	logic [3:0]        case_class;

	result_t   pending_results[$];
	stim_row_t directed_rows[$];
	int        mismatches     = 0;
	int        words_sent     = 0;
	int        words_checked  = 0;
	int        cycle_count    = 0;
	int        ready_stall_pct = 0;
	int        hold_count     = 0;
	bit        hold_go        = 1'b0;
	logic [8:0] classes_seen  = '0;

	residue_pattern_canonicalizer_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.first_bits      (first_bits),
		.second_bits     (second_bits),
		.row_select      (row_select),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.first_bits_out  (first_bits_out),
		.second_bits_out (second_bits_out),
		.case_class      (case_class)
	);

	always #4 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic logic [COL_W-1:0] column_rank(grid_t g, int c, bit first_only);
		logic [COL_W-1:0] k;
		k = '0;
		for (int r = 0; r < DIM; r++) begin
			if (first_only)
				k = {k[COL_W-2:0], g[c][r][1]};
			else
				k = {k[COL_W-3:0], g[c][r]};
		end
		return k;
	endfunction

	// stable descending insertion sort of the columns
	function automatic grid_t order_cols(grid_t g, bit first_only);
		logic [DIM-1:0][1:0] tmp;
		int j;
		for (int i = 1; i < DIM; i++) begin
			j = i;
			while (j > 0 && column_rank(g, j, first_only) > column_rank(g, j - 1, first_only)) begin
				tmp      = g[j];
				g[j]     = g[j - 1];
				g[j - 1] = tmp;
				j--;
			end
		end
		return g;
	endfunction

	function automatic grid_t flip_row(grid_t g, int r);
		for (int c = 0; c < DIM; c++)
			if (g[c][r][1])
				g[c][r][0] = ~g[c][r][0];
		return g;
	endfunction

	function automatic class_t class_of(grid_t g);
		grid_t l;
		int ones;
		l = order_cols(g, 1'b0);
		ones = 0;
		if (!l[2][0][1]) begin
			if (l[2][2][1])
				return l[4][4][1] ? CLASS_7 : CLASS_5;
			for (int r = 0; r < 5; r++) ones += l[0][r][1];
			return (ones > 2) ? CLASS_2 : CLASS_1;
		end
		// only column 0 row 0 decides between these two
		if (l[4][2][1])
			return l[0][0][1] ? CLASS_8 : CLASS_6;
		for (int r = 0; r < 5; r++) ones += l[2][r][1];
		return (ones > 2) ? CLASS_3 : CLASS_4;
	endfunction

	function automatic result_t canon_predict(logic [2:0] cmd, logic [NB-1:0] f,
			logic [NB-1:0] s, logic [2:0] rsel);
		grid_t g, t;
		result_t res;
		for (int r = 0; r < DIM; r++)
			for (int c = 0; c < DIM; c++)
				g[c][r] = {f[DIM*r+c], s[DIM*r+c]};
		case (cmd)
			CMD_ORDER: g = order_cols(g, 1'b0);
			CMD_MOD_ORDER: begin
				for (int r = 0; r < DIM; r++) g = flip_row(g, r);
				g = order_cols(g, 1'b0);
			end
			CMD_TRANSPOSE: begin
				t = g;
				for (int c = 0; c < DIM; c++)
					for (int r = 0; r < DIM; r++)
						g[c][r] = t[r][c];
				g = order_cols(g, 1'b0);
			end
			CMD_FIRST_ORDER: g = order_cols(g, 1'b1);
			CMD_TOGGLE_ROW: begin
				if (rsel < DIM) g = flip_row(g, rsel);
			end
			default: ;
		endcase
		for (int r = 0; r < DIM; r++)
			for (int c = 0; c < DIM; c++) begin
				res.first[DIM*r+c]  = g[c][r][1];
				res.second[DIM*r+c] = g[c][r][0];
			end
		res.cls = class_of(g);
		return res;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic logic [NB-1:0] rand36();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[NB-1:0];
	endfunction

	function automatic void add_row(logic [2:0] cmd, logic [NB-1:0] f, logic [NB-1:0] s,
			logic [2:0] rsel, bit typed, logic [NB-1:0] ef, logic [NB-1:0] es, class_t ec);
		stim_row_t row;
		row.cmd         = cmd;
		row.first       = f;
		row.second      = s;
		row.rsel        = rsel;
		row.typed       = typed;
		row.want.first  = ef;
		row.want.second = es;
		row.want.cls    = ec;
		directed_rows.push_back(row);
	endfunction

	task automatic draw_pattern(output logic [NB-1:0] f, output logic [NB-1:0] s);
		logic [5:0] ca, cb, pick, row_bits;
		ca   = 6'($urandom_range(63));
		cb   = 6'($urandom_range(63));
		pick = 6'($urandom_range(63));
		s    = rand36();
		case ($urandom_range(5))
			0: f = rand36();
			1: f = rand36() & rand36() & rand36();
			2: f = rand36() | rand36();
			3: begin
				// two column templates: many equal first-bit keys
				for (int c = 0; c < DIM; c++)
					for (int r = 0; r < DIM; r++)
						f[DIM*r+c] = pick[c] ? ca[DIM-1-r] : cb[DIM-1-r];
				if ($urandom_range(1)) s = rand36() & rand36();
			end
			4: begin
				// whole rows set or sparse
				for (int r = 0; r < DIM; r++) begin
					row_bits = $urandom_range(1) ? 6'h3F : 6'($urandom & $urandom);
					f[DIM*r +: DIM] = row_bits;
				end
			end
			default: begin
				f = $urandom_range(1) ? '1 : '0;
				if ($urandom_range(1)) s = $urandom_range(1) ? '1 : '0;
			end
		endcase
	endtask

	task automatic idle_sender(int pct);
		if ($urandom_range(99) < pct) begin
			in_valid    <= 1'b0;
			command     <= 3'($urandom_range(7));
			first_bits  <= rand36();
			second_bits <= rand36();
			row_select  <= 3'($urandom_range(7));
			do @(posedge clk); while ($urandom_range(99) < pct);
		end
	endtask

	task automatic send_word(logic [2:0] cmd, logic [NB-1:0] f, logic [NB-1:0] s,
			logic [2:0] rsel, bit typed, result_t want);
		result_t exp_r;
		in_valid    <= 1'b1;
		command     <= cmd;
		first_bits  <= f;
		second_bits <= s;
		row_select  <= rsel;
		do @(posedge clk); while (!in_ready);
		exp_r = typed ? want : canon_predict(cmd, f, s, rsel);
		pending_results.push_back(exp_r);
		words_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic run_random(int n, int send_pct, int stall_pct);
		logic [NB-1:0] f, s;
		logic [2:0] cmd, rsel;
		ready_stall_pct = stall_pct;
		repeat (n) begin
			draw_pattern(f, s);
			cmd  = ($urandom_range(99) < 90) ? 3'($urandom_range(4))
				: 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
			rsel = ($urandom_range(99) < 85) ? 3'($urandom_range(DIM - 1))
				: 3'($urandom_range(7, DIM));
			idle_sender(send_pct);
			send_word(cmd, f, s, rsel, 1'b0, '0);
		end
		wait_drained();
	endtask

	task automatic flag_mismatch(string what, logic [NB-1:0] got, logic [NB-1:0] want);
		if (mismatches < MAX_PRINTS)
			$display("[%0t] MISMATCH %s: got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// ---------------- receiver and checker ----------------

	always @(posedge clk) begin
		if (hold_go && hold_count < HOLD_CYCLES) begin
			out_ready  <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			out_ready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("word with nothing pending", first_bits_out, '0);
			end else begin
				want = pending_results.pop_front();
				if (first_bits_out !== want.first)
					flag_mismatch("first_bits_out", first_bits_out, want.first);
				if (second_bits_out !== want.second)
					flag_mismatch("second_bits_out", second_bits_out, want.second);
				if (case_class !== want.cls)
					flag_mismatch("case_class", NB'(case_class), NB'(want.cls));
				words_checked++;
			end
			if (case_class >= 1 && case_class <= 8)
				classes_seen[case_class] <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		// typed expectations: uniform patterns and pass-through cases
		add_row(CMD_ORDER,       '0, '0, 3'd0, 1, '0, '0, CLASS_1);
		add_row(CMD_ORDER,       '1, '1, 3'd0, 1, '1, '1, CLASS_8);
		add_row(CMD_ORDER,       '1, '0, 3'd0, 1, '1, '0, CLASS_8);
		add_row(CMD_ORDER,       '0, '1, 3'd0, 1, '0, '1, CLASS_1);
		add_row(CMD_MOD_ORDER,   '1, '1, 3'd0, 1, '1, '0, CLASS_8);
		add_row(CMD_MOD_ORDER,   '1, '0, 3'd0, 1, '1, '1, CLASS_8);
		add_row(CMD_TRANSPOSE,   '1, '0, 3'd0, 1, '1, '0, CLASS_8);
		// all first-bit keys tie, so the columns stay put
		add_row(CMD_FIRST_ORDER, '0, 36'h9A5C31E7B, 3'd0, 1, '0, 36'h9A5C31E7B, CLASS_1);
		add_row(CMD_TOGGLE_ROW,  '1, '0, 3'd0, 1, '1, 36'h00000003F, CLASS_8);
		add_row(CMD_TOGGLE_ROW,  '1, '0, 3'd5, 1, '1, 36'hFC0000000, CLASS_8);
		// row out of range: untouched
		add_row(CMD_TOGGLE_ROW,  '1, '0, 3'd6, 1, '1, '0, CLASS_8);
		add_row(CMD_TOGGLE_ROW,  '0, '1, 3'd7, 1, '0, '1, CLASS_1);
		// spare commands pass through
		add_row(CMD_SPARE_LO,    '1, '1, 3'd2, 1, '1, '1, CLASS_8);
		add_row(CMD_SPARE_HI,    '0, '0, 3'd3, 1, '0, '0, CLASS_1);
		// predicted rows
		add_row(CMD_ORDER,       36'h800000000, 36'h800000000, 3'd0, 0, '0, '0, CLASS_1);
		add_row(CMD_TRANSPOSE,   36'h00000003F, 36'h000000015, 3'd0, 0, '0, '0, CLASS_1);
		add_row(CMD_FIRST_ORDER, 36'h249249249, 36'h5A5A5A5A5, 3'd0, 0, '0, '0, CLASS_1);
		add_row(CMD_FIRST_ORDER, 36'h041041041, 36'hFFF000FFF, 3'd0, 0, '0, '0, CLASS_1);
		add_row(CMD_SPARE_MID,   36'h13579BDF0, 36'h2468ACE13, 3'd4, 0, '0, '0, CLASS_1);
		add_row(CMD_ORDER,       36'h00003F000, 36'h0F0F0F0F0, 3'd0, 0, '0, '0, CLASS_1);
		add_row(CMD_ORDER,       36'h0FC03F000, 36'h000000000, 3'd0, 0, '0, '0, CLASS_1);
		add_row(CMD_ORDER,       36'h001041041, 36'h123456789, 3'd0, 0, '0, '0, CLASS_1);
		add_row(CMD_MOD_ORDER,   36'hF0F0F0F0F, 36'h123456789, 3'd0, 0, '0, '0, CLASS_1);
		add_row(CMD_TOGGLE_ROW,  36'hA5A5A5A5A, 36'h3C3C3C3C3, 3'd3, 0, '0, '0, CLASS_1);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		ready_stall_pct = 0;
		foreach (directed_rows[i])
			send_word(directed_rows[i].cmd, directed_rows[i].first, directed_rows[i].second,
				directed_rows[i].rsel, directed_rows[i].typed, directed_rows[i].want);
		wait_drained();

		run_random(450, 0, 0);
		run_random(400, 51, 0);
		run_random(400, 0, 51);
		run_random(400, 7, 7);
		// long output hold-off with the sender streaming: pipeline fills, input stalls
		hold_go = 1'b1;
		run_random(200, 0, 0);

		repeat (16) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch("results never delivered", NB'(pending_results.size()), '0);

		$display("%0d words sent, %0d results compared; idle mixes: none, input, output, both,",
			words_sent, words_checked);
		$display("plus a %0d-cycle output hold-off; classes seen (8..1): %b",
			HOLD_CYCLES, classes_seen[8:1]);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/rpc_pkg.sv
src/rpc_prep.sv
src/rpc_sort_cell.sv
src/rpc_classify.sv
src/residue_pattern_canonicalizer_unit.sv
sim/tb_residue_pattern_canonicalizer_unit.sv
